// ===== hdl/fp32_add_mul_unit_top_defines.svh =====
// assertion macros for the fp32 add/multiply unit
`ifndef FP32_ADD_MUL_UNIT_TOP_DEFINES_SVH
`define FP32_ADD_MUL_UNIT_TOP_DEFINES_SVH

// condition holds in the same cycle
`define FAM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the next cycle
`define FAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fam_pkg.sv =====
`default_nettype none
package fam_pkg;

  localparam logic [31:0] DefaultNan = 32'hFFC0_0000;
  localparam logic [31:0] ExpField   = 32'h7F80_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;
  localparam logic [7:0]  GapLimit   = 8'd100;

  typedef enum logic {
    OpAdd = 1'b0,
    OpMul = 1'b1
  } op_e;

  // after unpack, alignment and multiply
  typedef struct packed {
    logic        special;
    logic [31:0] spec_val;
    logic        is_mul;
    logic        sub;
    logic        sign;
    logic [23:0] mb;
    logic [56:0] part;
    logic        lost;
    logic [47:0] prod;
    logic signed [10:0] et;
  } s1_t;

  // exact value t * 2^et
  typedef struct packed {
    logic        special;
    logic [31:0] spec_val;
    logic        sign;
    logic [57:0] t;
    logic signed [10:0] et;
  } s2_t;

  // normalized, shift decided
  typedef struct packed {
    logic        special;
    logic [31:0] spec_val;
    logic        sign;
    logic [57:0] t;
    logic        right;
    logic [5:0]  sh;
    logic [4:0]  ls;
    logic        ovf;
    logic [7:0]  exp_base;
  } s3_t;

endpackage
`default_nettype wire

// ===== hdl/fam_unpack.sv =====
`default_nettype none
module fam_unpack
  import fam_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire op_e         op_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output s1_t              data_o
);

  logic        valid_q;
  s1_t         data_q, data_d;
  logic [7:0]  ea, eb, effa, effb, eff_big, eff_small, d;
  logic [23:0] siga, sigb, ms;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, swap;
  logic [31:0] big;
  logic [55:0] wide, part;
  logic        lost;

  always_comb begin
    ea     = a_i[30:23];
    eb     = b_i[30:23];
    nan_a  = (ea == 8'hFF) && (a_i[22:0] != 23'd0);
    nan_b  = (eb == 8'hFF) && (b_i[22:0] != 23'd0);
    inf_a  = (a_i[30:0] == ExpField[30:0]);
    inf_b  = (b_i[30:0] == ExpField[30:0]);
    zero_a = (a_i[30:0] == 31'd0);
    zero_b = (b_i[30:0] == 31'd0);
    effa   = (ea == 8'd0) ? 8'd1 : ea;
    effb   = (eb == 8'd0) ? 8'd1 : eb;
    siga   = {ea != 8'd0, a_i[22:0]};
    sigb   = {eb != 8'd0, b_i[22:0]};

    swap      = {effb, sigb} > {effa, siga};
    big       = swap ? b_i : a_i;
    eff_big   = swap ? effb : effa;
    eff_small = swap ? effa : effb;
    ms        = swap ? siga : sigb;
    d         = eff_big - eff_small;

    wide = {ms, 32'd0};
    if (d >= 8'd64) begin
      part = '0;
      lost = 1'b1;
    end else begin
      part = wide >> d[5:0];
      lost = |(wide & ~({56{1'b1}} << d[5:0]));
    end

    data_d          = '0;
    data_d.is_mul   = (op_i == OpMul);
    data_d.sub      = a_i[31] ^ b_i[31];
    data_d.mb       = swap ? sigb : siga;
    data_d.part     = {part, 1'b0};
    data_d.lost     = lost;
    data_d.prod     = siga * sigb;
    data_d.special  = 1'b1;

    if (op_i == OpMul) begin
      data_d.sign = a_i[31] ^ b_i[31];
      data_d.et   = $signed({3'b0, effa}) + $signed({3'b0, effb}) - 11'sd300;
      if (nan_a)                 data_d.spec_val = a_i | QuietBit;
      else if (nan_b)            data_d.spec_val = b_i | QuietBit;
      else if (inf_a || inf_b)   data_d.spec_val = (zero_a || zero_b) ? DefaultNan
                                   : ({data_d.sign, 31'd0} | ExpField);
      else if (zero_a || zero_b) data_d.spec_val = {data_d.sign, 31'd0};
      else                       data_d.special  = 1'b0;
    end else begin
      data_d.sign = big[31];
      data_d.et   = $signed({3'b0, eff_big}) - 11'sd183;
      if (nan_a)                  data_d.spec_val = a_i | QuietBit;
      else if (nan_b)             data_d.spec_val = b_i | QuietBit;
      else if (inf_a && inf_b)    data_d.spec_val = (a_i[31] ^ b_i[31]) ? DefaultNan : a_i;
      else if (inf_a)             data_d.spec_val = a_i;
      else if (inf_b)             data_d.spec_val = b_i;
      else if (zero_a && zero_b)  data_d.spec_val = (a_i == b_i) ? a_i : 32'd0;
      else if (zero_a)            data_d.spec_val = b_i;
      else if (zero_b)            data_d.spec_val = a_i;
      else if (d > GapLimit)      data_d.spec_val = big;
      else                        data_d.special  = 1'b0;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// ===== hdl/fam_norm.sv =====
`default_nettype none
module fam_norm
  import fam_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire s1_t  data_i,
  output logic      valid_o,
  input  wire logic ready_i,
  output s3_t       data_o
);

  logic valid2_q, valid3_q, ready3;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  logic [5:0] p;
  logic signed [10:0] e, lsb, drop, negd;
  logic normal;

  // exact sum or product
  always_comb begin
    s2_d.special  = data_i.special;
    s2_d.spec_val = data_i.spec_val;
    s2_d.sign     = data_i.sign;
    s2_d.et       = data_i.et;
    if (data_i.is_mul) begin
      s2_d.t = {10'd0, data_i.prod};
    end else if (data_i.sub) begin
      s2_d.t = {1'b0, data_i.mb, 33'd0} - {1'b0, data_i.part} - 58'(data_i.lost);
    end else begin
      s2_d.t = {1'b0, data_i.mb, 33'd0} + {1'b0, data_i.part} + 58'(data_i.lost);
    end
  end

  // leading one and target lsb
  always_comb begin
    p = '0;
    for (int i = 0; i < 58; i++) begin
      if (s2_q.t[i]) p = 6'(i);
    end
    e      = s2_q.et + $signed({5'd0, p});
    normal = (e >= -11'sd126);
    lsb    = normal ? (e - 11'sd23) : -11'sd149;
    drop   = lsb - s2_q.et;
    negd   = -drop;

    s3_d.special  = s2_q.special;
    s3_d.spec_val = s2_q.spec_val;
    s3_d.sign     = s2_q.sign;
    s3_d.t        = s2_q.t;
    s3_d.right    = (drop > 11'sd0);
    s3_d.sh       = (drop > 11'sd63) ? 6'd63 : drop[5:0];
    s3_d.ls       = negd[4:0];
    s3_d.ovf      = (e > 11'sd127);
    s3_d.exp_base = normal ? 8'(e + 11'sd126) : 8'd0;
    // exact cancellation
    if (!s2_q.special && (s2_q.t == 58'd0)) begin
      s3_d.special  = 1'b1;
      s3_d.spec_val = 32'd0;
    end
  end

  assign ready3  = !valid3_q || ready_i;
  assign ready_o = !valid2_q || ready3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else begin
      if (ready_o) valid2_q <= valid_i;
      if (ready3)  valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) s2_q <= s2_d;
    if (ready3 && valid2_q) s3_q <= s3_d;
  end

  assign valid_o = valid3_q;
  assign data_o  = s3_q;

endmodule
`default_nettype wire

// ===== hdl/fam_round.sv =====
`default_nettype none
module fam_round
  import fam_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   valid_i,
  output logic        ready_o,
  input  wire s3_t    data_i,
  output logic        valid_o,
  input  wire logic   ready_i,
  output logic [31:0] result_o
);

  logic        valid_q;
  logic [31:0] res_q, res_d;
  logic [58:0] tx, ext;
  logic [23:0] m;
  logic        g, stk;
  logic [24:0] rnd;

  always_comb begin
    tx  = {data_i.t, 1'b0};
    ext = tx >> data_i.sh;
    m   = ext[24:1];
    g   = ext[0];
    stk = |(tx & ~({59{1'b1}} << data_i.sh));
    if (data_i.right) begin
      rnd = {1'b0, m} + 25'(g & (stk | m[0]));
    end else begin
      rnd = 25'(data_i.t[23:0]) << data_i.ls;
    end
    // a carry out of the significand bumps the exponent field
    if (data_i.special) begin
      res_d = data_i.spec_val;
    end else if (data_i.ovf) begin
      res_d = {data_i.sign, 31'd0} | ExpField;
    end else begin
      res_d = {data_i.sign, 31'd0} | ({1'b0, data_i.exp_base, 23'd0} + 32'(rnd));
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) res_q <= res_d;
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

// ===== hdl/fp32_add_mul_unit_top.sv =====
// channel   dir  tdata                          tuser
// s_axis    in   [31:0] operand_a [63:32] b     [0] opcode (0 add, 1 multiply)
// m_axis    out  [31:0] result_bits             -
//
// one item per cycle while the output is not stalled, through the stages unpack/multiply,
// sum, leading-one search and round, each stage a register with its own valid
// reset clears only the valid bits; no state is kept between items
// each stage moves when the next is empty or moving, so a stalled output
// holds its item while earlier stages keep filling bubbles
`default_nettype none
`include "fp32_add_mul_unit_top_defines.svh"
module fp32_add_mul_unit_top
  import fam_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // operand_a, operand_b
  input  wire logic        s_axis_tuser,  // opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata   // result_bits
);

  logic s1_valid, s1_ready, s3_valid, s3_ready;
  s1_t  s1_data;
  s3_t  s3_data;
  op_e  op;
  logic out_nan;

  assign op = op_e'(s_axis_tuser);

  fam_unpack u_unpack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .op_i    (op),
    .a_i     (s_axis_tdata[31:0]),
    .b_i     (s_axis_tdata[63:32]),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  fam_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .data_o  (s3_data)
  );

  fam_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s3_valid),
    .ready_o  (s3_ready),
    .data_i   (s3_data),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (m_axis_tdata)
  );

  assign out_nan = (m_axis_tdata[30:23] == 8'hFF) && (m_axis_tdata[22:0] != 23'd0);

  `FAM_ASSERT_NOW(a_empty_stage_ready, !s1_valid, s_axis_tready, "empty stage not ready")
  `FAM_ASSERT_NOW(a_nan_quiet, m_axis_tvalid && out_nan, m_axis_tdata[22], "nan not quiet")
  `FAM_ASSERT_NEXT(a_out_from_stage, !m_axis_tvalid && !s3_valid, !m_axis_tvalid, "no source")

endmodule
`default_nettype wire
